>>> rtl/qubit_gate_state_update_unit_assert.svh
// Assertion macros for the qubit gate state update unit.
`ifndef QUBIT_GATE_STATE_UPDATE_UNIT_ASSERT_SVH
`define QUBIT_GATE_STATE_UPDATE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define QG_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define QG_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/qgsu_pkg.sv
// Package with the shared types and constants of the gate unit.
`default_nettype none
package qgsu_pkg;
  localparam int QUBIT_COUNT = 10;
  localparam int STORE_SIZE = 1 << QUBIT_COUNT;
  localparam int IDX_W = QUBIT_COUNT;
  localparam int PAIR_W = QUBIT_COUNT - 1;
  localparam int NUM_REGS = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_GATE  = 2'd2;

  localparam logic [2:0] REG_U00_RE = 3'd0;
  localparam logic [2:0] REG_U00_IM = 3'd1;
  localparam logic [2:0] REG_U01_RE = 3'd2;
  localparam logic [2:0] REG_U01_IM = 3'd3;
  localparam logic [2:0] REG_U10_RE = 3'd4;
  localparam logic [2:0] REG_U10_IM = 3'd5;
  localparam logic [2:0] REG_U11_RE = 3'd6;
  localparam logic [2:0] REG_U11_IM = 3'd7;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_GATE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // Classified command handed from the front to the back.
  typedef struct packed {
    cmd_e              cmd;
    logic [IDX_W-1:0]  idx;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [3:0]        qubit;
    logic              err;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] u00_re, u00_im, u01_re, u01_im;
    logic signed [15:0] u10_re, u10_im, u11_re, u11_im;
  } gate_t;

  // Q6.29 sum to Q1.15 with half-up rounding and saturation.
  function automatic logic signed [15:0] round_sat(input logic signed [34:0] s);
    logic signed [34:0] b;
    logic signed [20:0] r;
    begin
      b = s + 35'sd8192;
      r = b[34:14];
      if (r > 21'sd32767) round_sat = 16'sh7fff;
      else if (r < -21'sd32768) round_sat = 16'sh8000;
      else round_sat = r[15:0];
    end
  endfunction
endpackage
`default_nettype wire

>>> rtl/qgsu_stream_if.sv
// Valid/ready channel interfaces for items and results.
`default_nettype none
interface qgsu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [9:0]  amp_index;
  logic signed [15:0] in_real;
  logic signed [15:0] in_imag;
  logic [3:0]  target_qubit;
  modport source (output valid, op, amp_index, in_real, in_imag, target_qubit,
                  input ready);
  modport sink (input valid, op, amp_index, in_real, in_imag, target_qubit,
                output ready);
endinterface

interface qgsu_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] out_real;
  logic signed [15:0] out_imag;
  logic        status;
  modport source (output valid, out_real, out_imag, status, input ready);
  modport sink (input valid, out_real, out_imag, status, output ready);
endinterface
`default_nettype wire

>>> rtl/qgsu_front.sv
// Front end: accepts items, classifies them and queues commands.
`default_nettype none
module qgsu_front
  import qgsu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qgsu_in_if.sink   in_ch,
  output cmd_t      cmd_o,
  output logic      cmd_valid_o,
  input  wire logic cmd_pop_i
);
  // Two-entry queue.
  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  cmd_t       cls;
  logic       push;

  assign in_ch.ready = (cnt_q != 2'd2);
  assign push = in_ch.valid && in_ch.ready;

  always_comb begin
    cls.idx   = in_ch.amp_index[IDX_W-1:0];
    cls.re    = in_ch.in_real;
    cls.im    = in_ch.in_imag;
    cls.qubit = in_ch.target_qubit;
    cls.err   = 1'b0;
    unique case (in_ch.op)
      OP_WRITE: cls.cmd = CMD_WRITE;
      OP_READ:  cls.cmd = CMD_READ;
      OP_GATE: begin
        cls.cmd = CMD_GATE;
        cls.err = ({1'b0, in_ch.target_qubit} >= 5'(QUBIT_COUNT));
      end
      default:  cls.cmd = CMD_NOP;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (cmd_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

  assign cmd_o = mem_q[rd_q];
  assign cmd_valid_o = (cnt_q != 2'd0);

  `include "qubit_gate_state_update_unit_assert.svh"
  `QG_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, cmd_pop_i, cnt_q != 2'd0)
  `QG_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= 2'd2)
  `QG_ASSERT_NXT(a_cnt_full_push, clk_i, rst_ni, push && !cmd_pop_i && cnt_q == 2'd1,
                 cnt_q == 2'd2)
endmodule
`default_nettype wire

>>> rtl/qgsu_back.sv
// Back end: amplitude store, gate sequencer and result register.
`default_nettype none
module qgsu_back
  import qgsu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cmd_t      cmd_i,
  input  wire logic cmd_valid_i,
  output logic      cmd_pop_o,
  input  gate_t     gate_i,
  qgsu_out_if.source out_ch
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD0  = 7'b0000010,
    S_RD1  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_SUM  = 7'b0010000,
    S_WR0  = 7'b0100000,
    S_WR1  = 7'b1000000
  } state_e;

  logic [31:0] mem_q [STORE_SIZE];
  logic [31:0] rdata_q;
  logic [IDX_W-1:0] raddr, waddr;
  logic [31:0] wdata;
  logic        we;
  logic        re_en;

  state_e state_q, state_d;
  logic [PAIR_W:0] pair_q;
  logic [3:0] qb_q;
  logic [IDX_W-1:0] i0, i1;
  logic signed [15:0] r0_q, m0_q, r1_q, m1_q;
  logic signed [31:0] p_q [16];
  logic signed [15:0] n_q [4];
  logic       ovalid_q;
  logic signed [15:0] ore_q, oim_q;
  logic       ost_q;
  logic       out_free;
  logic       out_xfer;
  logic [IDX_W-1:0] ext;

  assign out_xfer = out_ch.valid && out_ch.ready;
  assign out_free = !ovalid_q || out_xfer;

  // Insert the target-qubit zero bit into the pair counter.
  always_comb begin
    ext = '0;
    for (int b = 0; b < IDX_W; b++) begin
      if (b < qb_q) ext[b] = pair_q[b];
      else if (b > qb_q) ext[b] = pair_q[b-1];
    end
    i0 = ext;
    i1 = i0 | (IDX_W'(1) << qb_q);
  end

  always_comb begin
    re_en = 1'b0; raddr = i0; we = 1'b0; waddr = i0; wdata = {n_q[0], n_q[1]};
    unique case (state_q)
      S_IDLE: begin
        raddr = cmd_i.idx; re_en = cmd_valid_i && cmd_i.cmd == CMD_READ;
        waddr = cmd_i.idx; wdata = {cmd_i.re, cmd_i.im};
        we = cmd_valid_i && out_free && cmd_i.cmd == CMD_WRITE;
      end
      S_RD0: begin raddr = i0; re_en = 1'b1; end
      S_RD1: begin raddr = i1; re_en = 1'b1; end
      S_WR0: begin we = 1'b1; waddr = i0; wdata = {n_q[0], n_q[1]}; end
      S_WR1: begin we = 1'b1; waddr = i1; wdata = {n_q[2], n_q[3]}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re_en) rdata_q <= mem_q[raddr];
  end

  // Gate datapath: products then rounded sums.
  always_ff @(posedge clk_i) begin
    if (state_q == S_RD1) begin
      r0_q <= rdata_q[31:16]; m0_q <= rdata_q[15:0];
    end
    if (state_q == S_MUL) begin
      p_q[0]  <= gate_i.u00_re * r0_q;           p_q[1]  <= gate_i.u00_im * m0_q;
      p_q[2]  <= gate_i.u01_re * $signed(rdata_q[31:16]);
      p_q[3]  <= gate_i.u01_im * $signed(rdata_q[15:0]);
      p_q[4]  <= gate_i.u00_re * m0_q;           p_q[5]  <= gate_i.u00_im * r0_q;
      p_q[6]  <= gate_i.u01_re * $signed(rdata_q[15:0]);
      p_q[7]  <= gate_i.u01_im * $signed(rdata_q[31:16]);
      p_q[8]  <= gate_i.u10_re * r0_q;           p_q[9]  <= gate_i.u10_im * m0_q;
      p_q[10] <= gate_i.u11_re * $signed(rdata_q[31:16]);
      p_q[11] <= gate_i.u11_im * $signed(rdata_q[15:0]);
      p_q[12] <= gate_i.u10_re * m0_q;           p_q[13] <= gate_i.u10_im * r0_q;
      p_q[14] <= gate_i.u11_re * $signed(rdata_q[15:0]);
      p_q[15] <= gate_i.u11_im * $signed(rdata_q[31:16]);
    end
    if (state_q == S_SUM) begin
      n_q[0] <= round_sat(35'(p_q[0]) - 35'(p_q[1]) + 35'(p_q[2]) - 35'(p_q[3]));
      n_q[1] <= round_sat(35'(p_q[4]) + 35'(p_q[5]) + 35'(p_q[6]) + 35'(p_q[7]));
      n_q[2] <= round_sat(35'(p_q[8]) - 35'(p_q[9]) + 35'(p_q[10]) - 35'(p_q[11]));
      n_q[3] <= round_sat(35'(p_q[12]) + 35'(p_q[13]) + 35'(p_q[14]) + 35'(p_q[15]));
    end
  end

  logic start_gate;
  assign start_gate = cmd_valid_i && out_free && cmd_i.cmd == CMD_GATE && !cmd_i.err;

  always_comb begin
    state_d = state_q;
    cmd_pop_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          if (start_gate) state_d = S_RD0;
          else cmd_pop_o = 1'b1;
        end
      end
      S_RD0: state_d = S_RD1;
      S_RD1: state_d = S_MUL;
      S_MUL: state_d = S_SUM;
      S_SUM: state_d = S_WR0;
      S_WR0: state_d = S_WR1;
      S_WR1: begin
        if (pair_q == (PAIR_W+1)'((STORE_SIZE/2) - 1)) begin
          state_d = S_IDLE;
          cmd_pop_o = out_free;
          if (!out_free) state_d = S_WR1;
        end else state_d = S_RD0;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; pair_q <= '0; qb_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_pop_o) ovalid_q <= 1'b1;
      else if (out_xfer) ovalid_q <= 1'b0;
      if (state_q == S_IDLE && start_gate) begin
        pair_q <= '0; qb_q <= cmd_i.qubit;
      end
      if (state_q == S_WR1 && state_d == S_RD0) pair_q <= pair_q + 1'b1;
    end
  end

  logic rd_pend_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_pend_q <= 1'b0;
    else rd_pend_q <= (state_q == S_IDLE) && cmd_pop_o && cmd_i.cmd == CMD_READ;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      ore_q <= '0; oim_q <= '0;
      ost_q <= (cmd_i.cmd == CMD_GATE) && cmd_i.err;
    end else if (rd_pend_q) begin
      ore_q <= rdata_q[31:16]; oim_q <= rdata_q[15:0];
    end
  end

  assign out_ch.valid    = ovalid_q && !rd_pend_q;
  assign out_ch.out_real = ore_q;
  assign out_ch.out_imag = oim_q;
  assign out_ch.status   = ost_q;

  `include "qubit_gate_state_update_unit_assert.svh"
  `QG_ASSERT_IMP(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `QG_ASSERT_IMP(a_pop_free, clk_i, rst_ni, cmd_pop_o, out_free && cmd_valid_i)
  `QG_ASSERT_NXT(a_gate_wr, clk_i, rst_ni, state_q == S_WR0, state_q == S_WR1)
endmodule
`default_nettype wire

>>> rtl/qubit_gate_state_update_unit.sv
// Top level of the single-qubit gate state update unit.
//  Channel  Direction  Moves
//  in_ch    sink       op, amp_index, in_real, in_imag, target_qubit
//  out_ch   source     out_real, out_imag, status
//  cfg      write      eight Q2.14 gate coefficients
// A write, an error or an unused op passes the front queue and the output valid
// register before its output transfer; a read also waits for the store read data.
// A gate op walks 512 pairs, each through two reads, a multiply, a sum and two
// writes, before its output transfer.
// Reset clears control state and loads the identity gate; the store is
// undefined until written. A stalled output holds the back end while the
// front queue keeps taking up to two transfers.
`default_nettype none
module qubit_gate_state_update_unit
  import qgsu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qgsu_in_if.sink    in_ch,
  qgsu_out_if.source out_ch,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [15:0]          cfg_data_i
);
  gate_t gate_q;
  cmd_t  cmd;
  logic  cmd_valid, cmd_pop;

  // Gate coefficient registers; identity after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q <= '{u00_re: 16'sd16384, u11_re: 16'sd16384, default: 16'sd0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_U00_RE: gate_q.u00_re <= cfg_data_i;
        REG_U00_IM: gate_q.u00_im <= cfg_data_i;
        REG_U01_RE: gate_q.u01_re <= cfg_data_i;
        REG_U01_IM: gate_q.u01_im <= cfg_data_i;
        REG_U10_RE: gate_q.u10_re <= cfg_data_i;
        REG_U10_IM: gate_q.u10_im <= cfg_data_i;
        REG_U11_RE: gate_q.u11_re <= cfg_data_i;
        REG_U11_IM: gate_q.u11_im <= cfg_data_i;
        default: ;
      endcase
    end
  end

  qgsu_front u_front (
    .clk_i, .rst_ni, .in_ch, .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop)
  );

  qgsu_back u_back (
    .clk_i, .rst_ni, .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop),
    .gate_i(gate_q), .out_ch
  );
endmodule
`default_nettype wire
